// ----- src/gwb_pkg.sv -----
// Shared types, constants and helper functions of the matrix multiply block.
package gwb_pkg;

	localparam int STORE_DEPTH   = 64;
	localparam int ADDR_W        = 6;
	localparam int ELEM_W        = 16;
	localparam int DIM_W         = 4;
	localparam int MAX_DIM       = 8;
	localparam int FRACTION_BITS = 8;
	localparam int VALUE_W       = 35;
	localparam int PROD_W        = 2 * ELEM_W;
	localparam int ACC_W         = VALUE_W + 2;
	localparam int IDX_W         = 3;
	localparam int CFG_IDX_W     = 3;
	localparam int CFG_DATA_W    = 4;

	// input commands
	localparam logic [1:0] CMD_LOAD_A    = 2'd0;
	localparam logic [1:0] CMD_LOAD_B    = 2'd1;
	localparam logic [1:0] CMD_LOAD_BIAS = 2'd2;
	localparam logic [1:0] CMD_COMPUTE   = 2'd3;

	// bias modes
	localparam logic [1:0] BIAS_NONE   = 2'd0;
	localparam logic [1:0] BIAS_COLUMN = 2'd1;
	localparam logic [1:0] BIAS_FULL   = 2'd2;
	localparam logic [1:0] BIAS_SCALAR = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DEPTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B_TRANSPOSED = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS_MODE    = 3'd4;

	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] inner;
		logic [DIM_W-1:0] cols;
		logic             trans;
		logic [1:0]       bias_mode;
	} cfg_t;

	typedef struct packed {
		logic             valid;
		logic             mac;
		logic             bias_zero;
		logic             first;
		logic             last;
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
	} op_t;

	typedef struct packed {
		logic done;
		logic out_free;
	} status_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (int'(d) > MAX_DIM) begin
			r = DIM_W'(MAX_DIM);
		end
		return r;
	endfunction

	function automatic logic signed [VALUE_W-1:0] sat_value(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		logic signed [VALUE_W-1:0] r;
		hi = {{(ACC_W-VALUE_W+1){1'b0}}, {(VALUE_W-1){1'b1}}};
		lo = ~hi;
		r = v[VALUE_W-1:0];
		if (v > hi) begin
			r = hi[VALUE_W-1:0];
		end else if (v < lo) begin
			r = lo[VALUE_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- src/gwb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module gwb_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/gwb_seq.sv -----
// Sequencer: walks rows, columns and inner sum, one step per cycle; a new element waits for a free output.
module gwb_seq import gwb_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  cfg_t              cfg,
	input  status_t           status,
	output logic              busy,
	output logic [ADDR_W-1:0] a_addr,
	output logic [ADDR_W-1:0] b_addr,
	output logic [ADDR_W-1:0] bias_addr,
	output op_t               op
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN  = 1'b1;

	logic              state_q;
	logic [DIM_W-1:0]  m_q;
	logic [DIM_W-1:0]  n_q;
	logic [DIM_W-1:0]  k_q;
	logic [ADDR_W-1:0] row_base_q;
	logic [ADDR_W-1:0] col_base_q;
	logic [ADDR_W-1:0] a_addr_q;
	logic [ADDR_W-1:0] b_addr_q;
	logic [ADDR_W-1:0] elem_q;
	logic              inflight_q;

	logic              starting;
	logic              mac_op;
	logic              issue;
	logic              last_row;
	logic              last_col;
	logic [ADDR_W-1:0] b_step;
	logic [ADDR_W-1:0] k_ext;

	always_comb begin
		starting = (k_q == '0);
		mac_op   = (k_q != cfg.inner);
		issue    = (state_q == ST_RUN) && (!starting || (!inflight_q && status.out_free));
		last_row = (m_q == DIM_W'(cfg.rows - 1'b1));
		last_col = (n_q == DIM_W'(cfg.cols - 1'b1));
		k_ext    = ADDR_W'(cfg.inner);
		b_step   = cfg.trans ? ADDR_W'(1) : ADDR_W'(cfg.cols);
		unique case (cfg.bias_mode)
			BIAS_COLUMN: bias_addr = ADDR_W'(n_q);
			BIAS_FULL:   bias_addr = elem_q;
			BIAS_NONE,
			BIAS_SCALAR: bias_addr = '0;
			default:     bias_addr = '0;
		endcase
	end

	assign busy   = (state_q == ST_RUN);
	assign a_addr = a_addr_q;
	assign b_addr = b_addr_q;

	always_comb begin
		op.valid     = issue;
		op.mac       = mac_op;
		op.bias_zero = (cfg.bias_mode == BIAS_NONE);
		op.first     = starting;
		op.last      = last_row && last_col;
		op.row       = m_q[IDX_W-1:0];
		op.col       = n_q[IDX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			m_q        <= '0;
			n_q        <= '0;
			k_q        <= '0;
			row_base_q <= '0;
			col_base_q <= '0;
			a_addr_q   <= '0;
			b_addr_q   <= '0;
			elem_q     <= '0;
		end else if (state_q == ST_IDLE) begin
			// an empty shape gives no results: stay idle
			if (start && cfg.rows != '0 && cfg.cols != '0) begin
				state_q    <= ST_RUN;
				m_q        <= '0;
				n_q        <= '0;
				k_q        <= '0;
				row_base_q <= '0;
				col_base_q <= '0;
				a_addr_q   <= '0;
				b_addr_q   <= '0;
				elem_q     <= '0;
			end
		end else if (issue) begin
			if (mac_op) begin
				k_q      <= k_q + 1'b1;
				a_addr_q <= a_addr_q + 1'b1;
				b_addr_q <= b_addr_q + b_step;
			end else begin
				// bias step closes the element: advance to the next one
				k_q    <= '0;
				elem_q <= elem_q + 1'b1;
				if (last_col) begin
					n_q        <= '0;
					m_q        <= m_q + 1'b1;
					row_base_q <= row_base_q + k_ext;
					col_base_q <= '0;
					a_addr_q   <= row_base_q + k_ext;
					b_addr_q   <= '0;
					if (last_row) begin
						state_q <= ST_IDLE;
					end
				end else begin
					n_q        <= n_q + 1'b1;
					col_base_q <= col_base_q + k_ext;
					a_addr_q   <= row_base_q;
					b_addr_q   <= cfg.trans ? (col_base_q + k_ext) : (ADDR_W'(n_q) + 1'b1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= 1'b0;
		end else if (issue && starting) begin
			inflight_q <= 1'b1;
		end else if (status.done) begin
			inflight_q <= 1'b0;
		end
	end

	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (k_q <= cfg.inner))
		else $error("inner counter ran past the depth");

	a_mn_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) |-> (m_q < cfg.rows && n_q < cfg.cols))
		else $error("row or column counter out of range");

	a_done_started: assert property (@(posedge clk) disable iff (!arst_n)
		status.done |-> inflight_q)
		else $error("result finished for an element that was never started");

endmodule

// ----- src/gwb_mac.sv -----
// Shared multiply-accumulate unit with bias add, saturation and output register.
module gwb_mac import gwb_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  op_t                       op,
	input  logic signed [ELEM_W-1:0]  a_data,
	input  logic signed [ELEM_W-1:0]  b_data,
	input  logic signed [ELEM_W-1:0]  bias_data,
	input  logic                      out_tready,
	output logic                      out_valid,
	output logic signed [VALUE_W-1:0] out_value,
	output logic [IDX_W-1:0]          out_row,
	output logic [IDX_W-1:0]          out_col,
	output logic                      out_last,
	output status_t                   status
);

	op_t                      op_s1;
	op_t                      op_s2;
	logic signed [ACC_W-1:0]  val_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [IDX_W-1:0]         out_row_q;
	logic [IDX_W-1:0]         out_col_q;
	logic                     out_last_q;

	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0]  bias_ext;
	logic signed [ACC_W-1:0]  val_s1;
	logic signed [ACC_W-1:0]  sum;
	logic                     done;

	always_comb begin
		prod     = a_data * b_data;
		bias_ext = {{(ACC_W-ELEM_W){bias_data[ELEM_W-1]}}, bias_data} <<< FRACTION_BITS;
		if (op_s1.mac) begin
			val_s1 = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};
		end else if (op_s1.bias_zero) begin
			val_s1 = '0;
		end else begin
			val_s1 = bias_ext;
		end
		sum  = (op_s2.first ? '0 : acc_q) + val_s2;
		done = op_s2.valid && !op_s2.mac;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '0;
			op_s2 <= '0;
		end else begin
			op_s1 <= op;
			op_s2 <= op_s1;
		end
	end

	always_ff @(posedge clk) begin
		val_s2 <= val_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (op_s2.valid) begin
			acc_q <= sum;
		end
	end

	// load on a finished element, drop after the transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_value_q <= sat_value(sum);
			out_row_q   <= op_s2.row;
			out_col_q   <= op_s2.col;
			out_last_q  <= op_s2.last;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_value       = out_value_q;
	assign out_row         = out_row_q;
	assign out_col         = out_col_q;
	assign out_last        = out_last_q;
	assign status.done     = done;
	assign status.out_free = !out_valid_q || out_tready;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!out_valid_q || out_tready))
		else $error("result written over an untaken result");

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_tready) |=> out_valid_q)
		else $error("result dropped before its transfer");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_tready) |=>
			$stable({out_value_q, out_row_q, out_col_q, out_last_q}))
		else $error("result changed while waiting for its transfer");

endmodule

// ----- src/gemm_with_bias_broadcast_core.sv -----
// Top level of the fixed-point matrix multiply with broadcast bias.
//
// Load items write one signed Q8.8 element into the A, B or bias store; the block
// is ready again in the next cycle. A compute item walks every result Y[m][n] in
// row-major order through a single 16x16 multiplier and a 37-bit accumulator: each
// element issues K multiply steps and one bias step, then waits for its sum to reach
// the output register, and a run can stall on the result side. The input side is not
// ready while a run is being issued. Results are Q19.16 (2*FRACTION_BITS fraction
// bits), the bias is aligned by FRACTION_BITS, and the last result of a run carries
// tlast. A store entry must be written before a run reads it; the stores have no reset.
// Dimensions above MAX_DIM are held at MAX_DIM, store addresses wrap at 64, and a zero
// row or column count gives a run with no results. Write configuration only while idle.
module gemm_with_bias_broadcast_core import gwb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// slave stream: one command per transfer
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [23:0]           s_tdata,  // element_address[5:0], element_value[21:6], zero pad
	input  logic [1:0]            s_tuser,  // command[1:0]
	// master stream: one result element per transfer
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [47:0]           m_tdata,  // product_value[34:0], result_row[37:35],
	                                        // result_column[40:38], zero pad
	output logic                  m_tlast,  // last_result
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DIM_W-1:0] row_count_q;
	logic [DIM_W-1:0] inner_depth_q;
	logic [DIM_W-1:0] column_count_q;
	logic             b_transposed_q;
	logic [1:0]       bias_mode_q;

	cfg_t             cfg;
	op_t              op;
	status_t          status;
	logic             busy;
	logic             in_xfer;
	logic [1:0]       command;
	logic [ADDR_W-1:0] element_address;
	logic [ELEM_W-1:0] element_value;
	logic [ADDR_W-1:0] a_addr;
	logic [ADDR_W-1:0] b_addr;
	logic [ADDR_W-1:0] bias_addr;
	logic [ELEM_W-1:0] a_rd;
	logic [ELEM_W-1:0] b_rd;
	logic [ELEM_W-1:0] bias_rd;
	logic signed [VALUE_W-1:0] out_value;
	logic [IDX_W-1:0] out_row;
	logic [IDX_W-1:0] out_col;

	// register writes are always accepted
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q    <= DIM_W'(8);
			inner_depth_q  <= DIM_W'(8);
			column_count_q <= DIM_W'(8);
			b_transposed_q <= 1'b0;
			bias_mode_q    <= BIAS_NONE;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_ROW_COUNT:    row_count_q    <= cfg_data;
				REG_INNER_DEPTH:  inner_depth_q  <= cfg_data;
				REG_COLUMN_COUNT: column_count_q <= cfg_data;
				REG_B_TRANSPOSED: b_transposed_q <= cfg_data[0];
				REG_BIAS_MODE:    bias_mode_q    <= cfg_data[1:0];
				default: ;
			endcase
		end
	end

	// hold dimensions at the largest supported size
	always_comb begin
		cfg.rows      = clamp_dim(row_count_q);
		cfg.inner     = clamp_dim(inner_depth_q);
		cfg.cols      = clamp_dim(column_count_q);
		cfg.trans     = b_transposed_q;
		cfg.bias_mode = bias_mode_q;
	end

	// unpack the command transfer
	assign command         = s_tuser;
	assign element_address = s_tdata[ADDR_W-1:0];
	assign element_value   = s_tdata[ADDR_W+ELEM_W-1:ADDR_W];
	assign s_tready        = !busy;
	assign in_xfer         = s_tvalid && s_tready;

	gwb_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_a_store (
		.clk     (clk),
		.wr_en   (in_xfer && command == CMD_LOAD_A),
		.wr_addr (element_address),
		.wr_data (element_value),
		.rd_addr (a_addr),
		.rd_data (a_rd)
	);

	gwb_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_b_store (
		.clk     (clk),
		.wr_en   (in_xfer && command == CMD_LOAD_B),
		.wr_addr (element_address),
		.wr_data (element_value),
		.rd_addr (b_addr),
		.rd_data (b_rd)
	);

	gwb_ram #(.WIDTH(ELEM_W), .DEPTH(STORE_DEPTH)) u_bias_store (
		.clk     (clk),
		.wr_en   (in_xfer && command == CMD_LOAD_BIAS),
		.wr_addr (element_address),
		.wr_data (element_value),
		.rd_addr (bias_addr),
		.rd_data (bias_rd)
	);

	gwb_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_xfer && command == CMD_COMPUTE),
		.cfg       (cfg),
		.status    (status),
		.busy      (busy),
		.a_addr    (a_addr),
		.b_addr    (b_addr),
		.bias_addr (bias_addr),
		.op        (op)
	);

	gwb_mac u_mac (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.a_data     ($signed(a_rd)),
		.b_data     ($signed(b_rd)),
		.bias_data  ($signed(bias_rd)),
		.out_tready (m_tready),
		.out_valid  (m_tvalid),
		.out_value  (out_value),
		.out_row    (out_row),
		.out_col    (out_col),
		.out_last   (m_tlast),
		.status     (status)
	);

	// pack the result transfer, lowest field first
	assign m_tdata = {7'b0, out_col, out_row, out_value};

endmodule

// ----- sim/tb_gemm_with_bias_broadcast_core.sv -----
// Self-checking testbench for the fixed-point matrix multiply with broadcast bias.
`timescale 1ns / 1ps

module tb_gemm_with_bias_broadcast_core;
	import gwb_pkg::*;

	// extra cycles let pass after the last result before a register write
	localparam int SETTLE_CYCLES = 16;
	localparam int SCRIPT_ROWS   = 34;
	// input transfers over the whole run, directed part included
	localparam int ITEM_TARGET   = 120;

	typedef struct {
		logic signed [VALUE_W-1:0] value;
		logic [IDX_W-1:0]          row;
		logic [IDX_W-1:0]          col;
		logic                      last;
	} gemm_elem_t;

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	// one line of the directed script: an input transfer or a register write
	typedef struct packed {
		row_kind_e                 kind;
		logic [2:0]                sel;    // command, or register index
		logic [ADDR_W-1:0]         addr;
		logic [ELEM_W-1:0]         value;  // element value, or register data
		logic                      typed;  // expected sum given below
		logic signed [VALUE_W-1:0] want;
	} script_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [23:0]           s_tdata = '0;
	logic [1:0]            s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [47:0]           m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// shadow copy of the block's registers, at their reset values
	logic [DIM_W-1:0] cfg_rows  = 4'd8;
	logic [DIM_W-1:0] cfg_inner = 4'd8;
	logic [DIM_W-1:0] cfg_cols  = 4'd8;
	logic             cfg_trans = 1'b0;
	logic [1:0]       cfg_bias  = BIAS_NONE;

	// shadow stores, with a mark for every entry written so far
	logic signed [ELEM_W-1:0] a_mem    [STORE_DEPTH];
	logic signed [ELEM_W-1:0] b_mem    [STORE_DEPTH];
	logic signed [ELEM_W-1:0] bias_mem [STORE_DEPTH];
	bit                       a_set    [STORE_DEPTH];
	bit                       b_set    [STORE_DEPTH];
	bit                       bias_set [STORE_DEPTH];

	gemm_elem_t  pending_elems [$];
	gemm_elem_t  head_elem;
	script_row_t script [SCRIPT_ROWS];

	int fail_count = 0;
	int items_sent = 0;
	int sink_hold  = 0;
	bit calm_tail  = 1'b0;

	gemm_with_bias_broadcast_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Dimensions above MAX_DIM are held at MAX_DIM.
	function automatic int eff_dim(input logic [DIM_W-1:0] d);
		return (int'(d) > MAX_DIM) ? MAX_DIM : int'(d);
	endfunction

	task automatic flag_mismatch(input string what, input longint want, input longint got);
		fail_count++;
		if (fail_count <= 10) begin
			$display("mismatch in %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
		end
	endtask

	// Work out every element of one compute run, row-major, and queue it.
	task automatic predict_products();
		int     rows;
		int     depth;
		int     cols;
		int     ai;
		int     bi;
		longint acc;
		longint bias;
		gemm_elem_t e;
		rows  = eff_dim(cfg_rows);
		depth = eff_dim(cfg_inner);
		cols  = eff_dim(cfg_cols);
		for (int m = 0; m < rows; m++) begin
			for (int n = 0; n < cols; n++) begin
				acc = 0;
				for (int k = 0; k < depth; k++) begin
					ai  = (m * depth + k) % STORE_DEPTH;
					bi  = cfg_trans ? (n * depth + k) % STORE_DEPTH : (k * cols + n) % STORE_DEPTH;
					acc += longint'(a_mem[ai]) * longint'(b_mem[bi]);
				end
				case (cfg_bias)
					BIAS_COLUMN: bias = longint'(bias_mem[n % STORE_DEPTH]);
					BIAS_FULL:   bias = longint'(bias_mem[(m * cols + n) % STORE_DEPTH]);
					BIAS_SCALAR: bias = longint'(bias_mem[0]);
					default:     bias = 0;
				endcase
				// align the Q8.8 bias with the Q16.16 products
				acc += bias * (longint'(1) << FRACTION_BITS);
				e.value = acc[VALUE_W-1:0];
				e.row   = m[IDX_W-1:0];
				e.col   = n[IDX_W-1:0];
				e.last  = (m == rows - 1) && (n == cols - 1);
				pending_elems.push_back(e);
			end
		end
	endtask

	// Present one command, hold it until the transfer, then update the shadow state.
	// A compute with a typed sum queues that single element instead of the prediction.
	task automatic send_item(input logic [1:0] cmd, input logic [ADDR_W-1:0] addr,
			input logic [ELEM_W-1:0] value, input bit typed, input logic signed [VALUE_W-1:0] want);
		gemm_elem_t e;
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {2'b00, value, addr};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		case (cmd)
			CMD_LOAD_A: begin
				a_mem[addr] = value;
				a_set[addr] = 1'b1;
			end
			CMD_LOAD_B: begin
				b_mem[addr] = value;
				b_set[addr] = 1'b1;
			end
			CMD_LOAD_BIAS: begin
				bias_mem[addr] = value;
				bias_set[addr] = 1'b1;
			end
			default: begin
				if (typed) begin
					e.value = want;
					e.row   = '0;
					e.col   = '0;
					e.last  = 1'b1;
					pending_elems.push_back(e);
				end else begin
					predict_products();
				end
			end
		endcase
	endtask

	// Load every store entry that the next run will read and that was never written,
	// then issue the compute with junk in the address and value fields.
	task automatic run_compute(input bit typed, input logic signed [VALUE_W-1:0] want);
		int rows;
		int depth;
		int cols;
		int idx;
		rows  = eff_dim(cfg_rows);
		depth = eff_dim(cfg_inner);
		cols  = eff_dim(cfg_cols);
		for (int m = 0; m < rows; m++) begin
			for (int n = 0; n < cols; n++) begin
				for (int k = 0; k < depth; k++) begin
					idx = (m * depth + k) % STORE_DEPTH;
					if (!a_set[idx]) send_item(CMD_LOAD_A, idx[ADDR_W-1:0], 16'($urandom), 1'b0, '0);
					idx = cfg_trans ? (n * depth + k) % STORE_DEPTH : (k * cols + n) % STORE_DEPTH;
					if (!b_set[idx]) send_item(CMD_LOAD_B, idx[ADDR_W-1:0], 16'($urandom), 1'b0, '0);
				end
				case (cfg_bias)
					BIAS_COLUMN: idx = n % STORE_DEPTH;
					BIAS_FULL:   idx = (m * cols + n) % STORE_DEPTH;
					default:     idx = 0;
				endcase
				if (cfg_bias != BIAS_NONE && !bias_set[idx]) begin
					send_item(CMD_LOAD_BIAS, idx[ADDR_W-1:0], 16'($urandom), 1'b0, '0);
				end
			end
		end
		send_item(CMD_COMPUTE, 6'($urandom), 16'($urandom), typed, want);
	endtask

	// Write one register once every expected result is out and the block has gone quiet.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		s_tvalid <= 1'b0;
		while (pending_elems.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ROW_COUNT:    cfg_rows  = data;
			REG_INNER_DEPTH:  cfg_inner = data;
			REG_COLUMN_COUNT: cfg_cols  = data;
			REG_B_TRANSPOSED: cfg_trans = data[0];
			REG_BIAS_MODE:    cfg_bias  = data[1:0];
			default: ;
		endcase
	endtask

	// Mostly small dimensions; now and then the largest, a saturating one, or zero.
	function automatic logic [DIM_W-1:0] pick_dim();
		int r;
		r = $urandom_range(0, 19);
		if (r < 2) return 4'd8;
		if (r == 2) return 4'($urandom_range(9, 15));
		if (r == 3) return 4'd0;
		return 4'($urandom_range(1, 4));
	endfunction

	// Result side: stall now and then at random, never during the calm tail.
	always @(posedge clk) begin
		if (calm_tail) begin
			m_tready <= 1'b1;
		end else if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready  <= 1'b0;
		end else if ($urandom_range(0, 4) == 0) begin
			sink_hold <= $urandom_range(0, 2);
			m_tready  <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare every result transfer with the oldest expected element.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_elems.size() == 0) begin
				flag_mismatch("unexpected result", 0, longint'($signed(m_tdata[VALUE_W-1:0])));
			end else begin
				head_elem = pending_elems.pop_front();
				if ($signed(m_tdata[VALUE_W-1:0]) !== head_elem.value) begin
					flag_mismatch("product_value", longint'(head_elem.value),
						longint'($signed(m_tdata[VALUE_W-1:0])));
				end
				if (m_tdata[37:35] !== head_elem.row) begin
					flag_mismatch("result_row", longint'(head_elem.row), longint'(m_tdata[37:35]));
				end
				if (m_tdata[40:38] !== head_elem.col) begin
					flag_mismatch("result_column", longint'(head_elem.col),
						longint'(m_tdata[40:38]));
				end
				if (m_tlast !== head_elem.last) begin
					flag_mismatch("last_result", longint'(head_elem.last), longint'(m_tlast));
				end
			end
		end
	end

	initial begin
		int        n_ops;
		int        r;
		logic [1:0] cmd;

		// Directed part: extremes of the element values and addresses, every bias mode,
		// the transposed layout, zero depth, zero rows and columns, and saturating sizes.
		script = '{
			'{ROW_CFG,  REG_ROW_COUNT,    6'd0,  16'd1,      1'b0, 35'sd0},
			'{ROW_CFG,  REG_INNER_DEPTH,  6'd0,  16'd1,      1'b0, 35'sd0},
			'{ROW_CFG,  REG_COLUMN_COUNT, 6'd0,  16'd1,      1'b0, 35'sd0},
			'{ROW_CFG,  REG_B_TRANSPOSED, 6'd0,  16'd0,      1'b0, 35'sd0},
			'{ROW_CFG,  REG_BIAS_MODE,    6'd0,  BIAS_NONE,  1'b0, 35'sd0},
			'{ROW_ITEM, CMD_LOAD_A,       6'd0,  16'h8000,   1'b0, 35'sd0},
			'{ROW_ITEM, CMD_LOAD_B,       6'd0,  16'h8000,   1'b0, 35'sd0},
			// most negative squared
			'{ROW_ITEM, CMD_COMPUTE,      6'd63, 16'hFFFF,   1'b1, 35'sd1073741824},
			'{ROW_ITEM, CMD_LOAD_A,       6'd0,  16'h7FFF,   1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd63, 16'hFFFF,   1'b1, -35'sd1073709056},
			'{ROW_ITEM, CMD_LOAD_BIAS,    6'd0,  16'h8000,   1'b0, 35'sd0},
			'{ROW_CFG,  REG_BIAS_MODE,    6'd0,  BIAS_SCALAR, 1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd0,  16'h0000,   1'b1, -35'sd1082097664},
			// zero depth leaves the bias alone
			'{ROW_CFG,  REG_INNER_DEPTH,  6'd0,  16'd0,      1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd0,  16'h0000,   1'b1, -35'sd8388608},
			'{ROW_CFG,  REG_BIAS_MODE,    6'd0,  BIAS_NONE,  1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd21, 16'h5A5A,   1'b1, 35'sd0},
			'{ROW_ITEM, CMD_LOAD_B,       6'd63, 16'h7FFF,   1'b0, 35'sd0},
			'{ROW_ITEM, CMD_LOAD_A,       6'd63, 16'h0001,   1'b0, 35'sd0},
			// zero rows: a run with no results
			'{ROW_CFG,  REG_ROW_COUNT,    6'd0,  16'd0,      1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd0,  16'h0000,   1'b0, 35'sd0},
			'{ROW_CFG,  REG_ROW_COUNT,    6'd0,  16'd15,     1'b0, 35'sd0},
			'{ROW_CFG,  REG_INNER_DEPTH,  6'd0,  16'd2,      1'b0, 35'sd0},
			'{ROW_CFG,  REG_COLUMN_COUNT, 6'd0,  16'd3,      1'b0, 35'sd0},
			'{ROW_CFG,  REG_B_TRANSPOSED, 6'd0,  16'd1,      1'b0, 35'sd0},
			'{ROW_CFG,  REG_BIAS_MODE,    6'd0,  BIAS_COLUMN, 1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd0,  16'h0000,   1'b0, 35'sd0},
			'{ROW_CFG,  REG_BIAS_MODE,    6'd0,  BIAS_FULL,  1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd0,  16'h0000,   1'b0, 35'sd0},
			// zero columns: no results either
			'{ROW_CFG,  REG_COLUMN_COUNT, 6'd0,  16'd0,      1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd0,  16'h0000,   1'b0, 35'sd0},
			// depth above the limit saturates
			'{ROW_CFG,  REG_INNER_DEPTH,  6'd0,  16'd9,      1'b0, 35'sd0},
			'{ROW_CFG,  REG_COLUMN_COUNT, 6'd0,  16'd1,      1'b0, 35'sd0},
			'{ROW_ITEM, CMD_COMPUTE,      6'd0,  16'h0000,   1'b0, 35'sd0}
		};

		// hold reset at the start, then release it at a rising edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_CFG) begin
				write_reg(script[i].sel, script[i].value[CFG_DATA_W-1:0]);
			end else if (script[i].sel[1:0] == CMD_COMPUTE) begin
				run_compute(script[i].typed, script[i].want);
			end else begin
				send_item(script[i].sel[1:0], script[i].addr, script[i].value, 1'b0, '0);
			end
		end

		// Random phases: fresh settings, a run of loads with computes among them,
		// and a compute to close each phase.
		do begin
			write_reg(REG_ROW_COUNT, pick_dim());
			write_reg(REG_INNER_DEPTH, pick_dim());
			write_reg(REG_COLUMN_COUNT, pick_dim());
			write_reg(REG_B_TRANSPOSED, 4'($urandom_range(0, 1)));
			write_reg(REG_BIAS_MODE, 4'($urandom_range(0, 3)));
			n_ops = $urandom_range(3, 10);
			for (int i = 0; i < n_ops; i++) begin
				r = $urandom_range(0, 9);
				if (r >= 8) begin
					run_compute(1'b0, '0);
				end else begin
					cmd = (r < 3) ? CMD_LOAD_A : (r < 6) ? CMD_LOAD_B : CMD_LOAD_BIAS;
					send_item(cmd, 6'($urandom), 16'($urandom), 1'b0, '0);
				end
			end
			run_compute(1'b0, '0);
		end while (items_sent < ITEM_TARGET - 8);

		// drop idling for the last stretch: a few computes back to back
		calm_tail = 1'b1;
		repeat (4) run_compute(1'b0, '0);

		// drain what is still expected, then give the block time to settle
		s_tvalid <= 1'b0;
		while (pending_elems.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// overall time limit: a hang anywhere ends the run as a failure
	initial begin
		#5_000_000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
src/gwb_pkg.sv
src/gwb_ram.sv
src/gwb_seq.sv
src/gwb_mac.sv
src/gemm_with_bias_broadcast_core.sv
sim/tb_gemm_with_bias_broadcast_core.sv
